// File: hdl/tsvm_pkg.sv
`timescale 1ns / 1ps

package tsvm_pkg;

  // Store geometry
  localparam int SAMPLE_DEPTH = 65536;
  localparam int SEEK_SLOTS   = 9;
  localparam int REGIONS      = 2 + SEEK_SLOTS;
  localparam int RAM_WORDS    = REGIONS * SAMPLE_DEPTH;
  localparam int RAM_AW       = $clog2(RAM_WORDS);
  localparam int POS_W        = $clog2(SAMPLE_DEPTH) + 1;

  // Mixer gain, 0.2 in Q15
  localparam logic signed [31:0] GAIN_Q15 = 32'sd6554;

  // Item codes
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_IO      = 2'd1;
  localparam logic [1:0] MODE_PATTERN = 2'd2;
  localparam logic [1:0] MODE_LOAD    = 2'd3;

  // Region codes
  localparam logic [3:0] REGION_SPIN_UP = 4'd0;
  localparam logic [3:0] REGION_SPIN    = 4'd1;
  localparam logic [3:0] REGION_SEEK0   = 4'd2;

  // Register indexes
  localparam logic [1:0] REG_NOISE_MODE = 2'd0;
  localparam logic [1:0] REG_DISK_KIND  = 2'd1;
  localparam logic [1:0] REG_SEEK_COUNT = 2'd2;

  localparam logic       DISK_FLOPPY = 1'b0;
  localparam logic [3:0] MOD_TEN     = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_SPIN,
    S_TICK_SEEK,
    S_TICK_SUM,
    S_TICK_OUT,
    S_EV_START,
    S_EV_MOD10,
    S_EV_PICK,
    S_EV_PICKWAIT,
    S_EV_COMMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [14:0] dividend;
    logic [3:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } mod_rsp_t;

endpackage

// File: hdl/triggered_sample_voice_mixer_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// item      item_valid / item_stall   mode region address sample_value last_word
//                                     same_path rand_first rand_second
// frame     frame_valid / frame_stall frame_sample
// config    APB psel penable pwrite   paddr[3:0] pwdata prdata, pready tied high
//
// A load, pattern update or ignored item is handled in idle; a tick steps through
// two reads of the single-port sample memory, add and multiply, output load.
// An I/O event ends at its start while a seek still plays, commits a direct slot
// choice without a pick, and runs the serial remainder to pick among loaded slots.
// Synchronous reset clears control state and all region lengths; the sample
// memory is not cleared. A stalled frame holds the tick in its last cycle.
module triggered_sample_voice_mixer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         mode,
  input  logic [3:0]         region,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample_value,
  input  logic               last_word,
  input  logic               same_path,
  input  logic [14:0]        rand_first,
  input  logic [14:0]        rand_second,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic signed [15:0] frame_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = tsvm_pkg::RAM_AW;
  localparam int PW = tsvm_pkg::POS_W;

  tsvm_pkg::state_t state, state_next;

  // Configuration
  logic [1:0] noise_mode;
  logic       disk_kind;
  logic [3:0] seek_count;

  // Voice state
  logic [PW-1:0] region_length [tsvm_pkg::REGIONS];
  logic [PW-1:0] spin_up_position;
  logic          spin_up_cleared;
  logic [PW-1:0] spin_position;
  logic          spin_armed;
  logic          seek_active;
  logic [3:0]    seek_slot;
  logic [PW-1:0] seek_position;
  logic          sequential_access;

  // Tick pipeline
  logic               spin_use, seek_use;
  logic [AW-1:0]      spin_addr, seek_addr;
  logic signed [15:0] spin_data;
  logic signed [31:0] prod;

  // Event
  logic [14:0] ev_r1, ev_r2, pick_r;
  logic        pick_skip2;
  logic [3:0]  slot_idx;

  // Memory and remainder unit
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [15:0]        ram_rdata;
  tsvm_pkg::mod_req_t mod_req;
  tsvm_pkg::mod_rsp_t mod_rsp;

  tsvm_sample_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample_value),
    .rdata (ram_rdata)
  );

  tsvm_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      tsvm_pkg::REG_NOISE_MODE: prdata = {30'd0, noise_mode};
      tsvm_pkg::REG_DISK_KIND:  prdata = {31'd0, disk_kind};
      tsvm_pkg::REG_SEEK_COUNT: prdata = {28'd0, seek_count};
      default:                  prdata = '0;
    endcase
  end

  // Common decodes
  logic          accept;
  logic          load_ok;
  logic [3:0]    slots_n;
  logic [PW-1:0] up_len, sp_len, sk_len;
  logic          seek_busy;
  logic [8:0]    nonempty;

  assign accept  = item_valid & ~item_stall;
  assign load_ok = (mode == tsvm_pkg::MODE_LOAD) &&
                   (region < 4'(tsvm_pkg::REGIONS)) &&
                   ({5'd0, address} < 21'(tsvm_pkg::SAMPLE_DEPTH));
  assign slots_n = (seek_count < 4'(tsvm_pkg::SEEK_SLOTS)) ? seek_count
                                                            : 4'(tsvm_pkg::SEEK_SLOTS);
  assign up_len  = noise_mode[1] ? region_length[tsvm_pkg::REGION_SPIN_UP] : '0;
  assign sp_len  = noise_mode[1] ? region_length[tsvm_pkg::REGION_SPIN] : '0;
  assign sk_len  = region_length[4'(seek_slot + tsvm_pkg::REGION_SEEK0)];
  assign seek_busy = seek_active && (seek_position < sk_len);

  always_comb begin
    nonempty = '0;
    for (int k = 0; k < tsvm_pkg::SEEK_SLOTS; k++) begin
      nonempty[k] = region_length[k + 2] != '0;
    end
  end

  // Tick decisions from the current voice state
  logic          tk_spin_use, tk_seek_use, tk_spin_reg;
  logic [PW-1:0] tk_spin_pos;
  logic [PW-1:0] up_pos_next, spin_pos_next, seek_pos_next;
  logic          cleared_next, active_next;

  always_comb begin
    tk_spin_use   = 1'b0;
    tk_spin_reg   = 1'b0;
    tk_spin_pos   = '0;
    up_pos_next   = spin_up_position;
    cleared_next  = spin_up_cleared;
    spin_pos_next = spin_position;
    if (!spin_up_cleared && up_len != '0) begin
      if (disk_kind && spin_up_position < up_len) begin
        tk_spin_use = 1'b1;
        tk_spin_pos = spin_up_position;
        up_pos_next = spin_up_position + 1'b1;
      end else begin
        cleared_next = 1'b1;
      end
    end else if (sp_len != '0) begin
      if (disk_kind) begin
        tk_spin_use   = 1'b1;
        tk_spin_reg   = 1'b1;
        tk_spin_pos   = (spin_position >= sp_len) ? '0 : spin_position;
        spin_pos_next = tk_spin_pos + 1'b1;
      end else if (spin_armed && spin_position < sp_len) begin
        tk_spin_use   = 1'b1;
        tk_spin_reg   = 1'b1;
        tk_spin_pos   = spin_position;
        spin_pos_next = spin_position + 1'b1;
      end
    end
    tk_seek_use   = seek_busy;
    seek_pos_next = seek_busy ? seek_position + 1'b1 : seek_position;
    active_next   = seek_active && (seek_pos_next < sk_len);
  end

  // Slot choice helpers
  logic [8:0] pick_mask;
  logic [3:0] pick_cnt;
  logic [3:0] pick_sel;
  logic [3:0] pick_seen;
  logic       pick_found;
  logic       ev_direct, ev_mod10;

  // first draw mod 10 by reciprocal multiply, exact for 15-bit values
  logic [30:0] r1_recip;
  logic [11:0] r1_div10;
  logic [3:0]  r1_mod10;

  assign r1_recip = 31'(ev_r1) * 31'(17'd52429);
  assign r1_div10 = r1_recip[30:19];
  assign r1_mod10 = 4'(ev_r1 - 15'({3'd0, r1_div10} * 15'(tsvm_pkg::MOD_TEN)));

  always_comb begin
    pick_mask = '0;
    pick_cnt  = '0;
    for (int k = 0; k < tsvm_pkg::SEEK_SLOTS; k++) begin
      pick_mask[k] = nonempty[k] && (4'(k) < slots_n) && !(pick_skip2 && k < 2);
      pick_cnt     = pick_cnt + {3'd0, pick_mask[k]};
    end
  end

  always_comb begin
    pick_sel   = '0;
    pick_seen  = '0;
    pick_found = 1'b0;
    for (int k = 0; k < tsvm_pkg::SEEK_SLOTS; k++) begin
      if (pick_mask[k]) begin
        if (!pick_found && pick_seen == mod_rsp.rem) begin
          pick_sel   = 4'(k);
          pick_found = 1'b1;
        end
        pick_seen = pick_seen + 4'd1;
      end
    end
  end

  assign ev_direct = sequential_access ||
                     (disk_kind == tsvm_pkg::DISK_FLOPPY && slots_n <= 4'd2);
  assign ev_mod10  = !ev_direct && disk_kind == tsvm_pkg::DISK_FLOPPY;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      tsvm_pkg::S_IDLE: begin
        if (item_valid) begin
          if (mode == tsvm_pkg::MODE_TICK) begin
            state_next = tsvm_pkg::S_TICK_SPIN;
          end else if (mode == tsvm_pkg::MODE_IO && noise_mode != 2'd0) begin
            state_next = tsvm_pkg::S_EV_START;
          end
        end
      end
      tsvm_pkg::S_TICK_SPIN: state_next = tsvm_pkg::S_TICK_SEEK;
      tsvm_pkg::S_TICK_SEEK: state_next = tsvm_pkg::S_TICK_SUM;
      tsvm_pkg::S_TICK_SUM:  state_next = tsvm_pkg::S_TICK_OUT;
      tsvm_pkg::S_TICK_OUT: begin
        if (!frame_valid || !frame_stall) state_next = tsvm_pkg::S_IDLE;
      end
      tsvm_pkg::S_EV_START: begin
        if (seek_busy || slots_n == 4'd0) state_next = tsvm_pkg::S_IDLE;
        else if (ev_direct)               state_next = tsvm_pkg::S_EV_COMMIT;
        else if (ev_mod10)                state_next = tsvm_pkg::S_EV_MOD10;
        else                              state_next = tsvm_pkg::S_EV_PICK;
      end
      tsvm_pkg::S_EV_MOD10: begin
        state_next = (r1_mod10 < 4'd8) ? tsvm_pkg::S_EV_COMMIT : tsvm_pkg::S_EV_PICK;
      end
      tsvm_pkg::S_EV_PICK: begin
        state_next = (pick_cnt == 4'd0) ? tsvm_pkg::S_EV_COMMIT : tsvm_pkg::S_EV_PICKWAIT;
      end
      tsvm_pkg::S_EV_PICKWAIT: begin
        if (mod_rsp.done) state_next = tsvm_pkg::S_EV_COMMIT;
      end
      tsvm_pkg::S_EV_COMMIT: state_next = tsvm_pkg::S_IDLE;
      default: state_next = tsvm_pkg::S_IDLE;
    endcase
  end

  // Outputs: stall, memory port, remainder requests
  always_comb begin
    item_stall = 1'b1;
    ram_we     = 1'b0;
    ram_addr   = AW'(region) * AW'(tsvm_pkg::SAMPLE_DEPTH) + AW'(address);
    mod_req    = '0;
    case (state)
      tsvm_pkg::S_IDLE: begin
        item_stall = 1'b0;
        ram_we     = item_valid && load_ok;
      end
      tsvm_pkg::S_TICK_SPIN: ram_addr = spin_addr;
      tsvm_pkg::S_TICK_SEEK: ram_addr = seek_addr;
      tsvm_pkg::S_EV_PICK: begin
        mod_req.start    = pick_cnt != 4'd0;
        mod_req.dividend = pick_r;
        mod_req.divisor  = pick_cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tsvm_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_mode <= 2'd0;
      disk_kind  <= 1'b1;
      seek_count <= 4'd9;
    end else if (cfg_we) begin
      case (paddr[3:2])
        tsvm_pkg::REG_NOISE_MODE: noise_mode <= pwdata[1:0];
        tsvm_pkg::REG_DISK_KIND:  disk_kind  <= pwdata[0];
        tsvm_pkg::REG_SEEK_COUNT: seek_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Voice state, region lengths and event handling
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tsvm_pkg::REGIONS; k++) region_length[k] <= '0;
      spin_up_position  <= '0;
      spin_up_cleared   <= 1'b0;
      spin_position     <= '0;
      spin_armed        <= 1'b0;
      seek_active       <= 1'b0;
      seek_slot         <= '0;
      seek_position     <= '0;
      sequential_access <= 1'b0;
      spin_use          <= 1'b0;
      seek_use          <= 1'b0;
      pick_skip2        <= 1'b0;
      slot_idx          <= '0;
    end else begin
      case (state)
        tsvm_pkg::S_IDLE: begin
          if (accept) begin
            ev_r1 <= rand_first;
            ev_r2 <= rand_second;
            if (mode == tsvm_pkg::MODE_LOAD && load_ok && last_word) begin
              region_length[region] <= {1'b0, address} + 1'b1;
            end
            if (mode == tsvm_pkg::MODE_PATTERN && noise_mode != 2'd0) begin
              sequential_access <= same_path;
            end
            if (mode == tsvm_pkg::MODE_TICK) begin
              spin_use  <= (noise_mode != 2'd0) && tk_spin_use;
              seek_use  <= (noise_mode != 2'd0) && tk_seek_use;
              spin_addr <= AW'(tk_spin_reg) * AW'(tsvm_pkg::SAMPLE_DEPTH)
                         + AW'(tk_spin_pos[PW-2:0]);
              seek_addr <= AW'(4'(seek_slot + tsvm_pkg::REGION_SEEK0))
                         * AW'(tsvm_pkg::SAMPLE_DEPTH) + AW'(seek_position[PW-2:0]);
              if (noise_mode != 2'd0) begin
                spin_up_position <= up_pos_next;
                spin_up_cleared  <= cleared_next;
                spin_position    <= spin_pos_next;
                seek_position    <= seek_pos_next;
                seek_active      <= active_next;
              end
            end
          end
        end
        tsvm_pkg::S_EV_START: begin
          // floppy spin restart
          if (disk_kind == tsvm_pkg::DISK_FLOPPY && sp_len != '0 &&
              !(spin_armed && spin_position < sp_len)) begin
            spin_position <= '0;
            spin_armed    <= 1'b1;
          end
          slot_idx   <= (slots_n == 4'd1) ? 4'd0 : {3'd0, ev_r1[0]};
          pick_skip2 <= 1'b0;
          pick_r     <= ev_r1;
        end
        tsvm_pkg::S_EV_MOD10: begin
          slot_idx   <= {3'd0, ev_r2[0]};
          pick_skip2 <= 1'b1;
          pick_r     <= ev_r2;
        end
        tsvm_pkg::S_EV_PICK: begin
          if (pick_cnt == 4'd0) slot_idx <= '0;
        end
        tsvm_pkg::S_EV_PICKWAIT: begin
          if (mod_rsp.done) slot_idx <= pick_sel;
        end
        tsvm_pkg::S_EV_COMMIT: begin
          if (slot_idx < slots_n && nonempty[slot_idx]) begin
            seek_slot     <= slot_idx;
            seek_position <= '0;
            seek_active   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Mix datapath
  logic signed [16:0] mix_sum;
  assign mix_sum = 17'(spin_data) +
                   (seek_use ? 17'(signed'(ram_rdata)) : 17'sd0);

  always_ff @(posedge clk) begin
    if (state == tsvm_pkg::S_TICK_SEEK) begin
      spin_data <= spin_use ? signed'(ram_rdata) : 16'sd0;
    end
    if (state == tsvm_pkg::S_TICK_SUM) begin
      prod <= 32'(mix_sum) * tsvm_pkg::GAIN_Q15;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (state == tsvm_pkg::S_TICK_OUT && (!frame_valid || !frame_stall)) begin
      frame_valid  <= 1'b1;
      frame_sample <= prod[30:15];
    end else if (frame_valid && !frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  // Checks
  a_frame_src: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_valid) |-> $past(state) == tsvm_pkg::S_TICK_OUT)
    else $error("frame raised outside output state");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    seek_active |-> seek_slot < 4'(tsvm_pkg::SEEK_SLOTS))
    else $error("seek slot out of range");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> state == tsvm_pkg::S_EV_PICKWAIT)
    else $error("remainder result with no waiting state");

  a_no_write_in_tick: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == tsvm_pkg::S_IDLE)
    else $error("memory write outside idle");

endmodule

// File: hdl/tsvm_sample_ram.sv
`timescale 1ns / 1ps

// Single-port sample store, one access per cycle, registered read
module tsvm_sample_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [tsvm_pkg::RAM_AW-1:0]     addr,
  input  logic [15:0]                     wdata,
  output logic [15:0]                     rdata
);

  logic [15:0] mem [tsvm_pkg::RAM_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/tsvm_mod_unit.sv
`timescale 1ns / 1ps

// Bit-serial remainder of a 15-bit value by a small divisor, one bit a cycle
module tsvm_mod_unit (
  input  logic               clk,
  input  logic               rst,
  input  tsvm_pkg::mod_req_t req,
  output tsvm_pkg::mod_rsp_t rsp
);

  logic        busy;
  logic [3:0]  count;
  logic [14:0] shift;
  logic [3:0]  divisor;
  logic [3:0]  rem;
  logic        done;
  logic [4:0]  trial;

  assign trial = {rem, shift[14]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= 4'd15;
        shift   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        // restoring step
        if (trial >= {1'b0, divisor}) begin
          rem <= 4'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[3:0];
        end
        shift <= {shift[13:0], 1'b0};
        count <= count - 4'd1;
        if (count == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule
